// File: src/assert_macros.svh
// Assertion macros used by the top-level RTL file of the escape word unescaper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge of aclk outside reset.
`define EWU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Check that a condition is never true at a rising edge of aclk outside reset.
`define EWU_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

// File: src/ewu_pkg.sv
// Package with types, constants and word tables of the escape word unescaper.
`timescale 1ns / 1ps

package ewu_pkg;

    // Character codes.
    localparam logic [7:0] BACKSLASH_CHAR = 8'h5C;
    localparam logic [7:0] LINEFEED_CHAR  = 8'h0A;
    localparam logic [7:0] DQUOTE_CHAR    = 8'h22;
    localparam logic [7:0] LETTER_N       = 8'h6E;
    localparam logic [7:0] LETTER_Q       = 8'h71;

    // Word lengths.
    localparam logic [2:0] NEWLINE_LEN = 3'd7;
    localparam logic [2:0] QUOTE_LEN   = 3'd5;

    // Default depth of the request queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Which escape word is being matched.
    typedef enum logic {
        WORD_NEWLINE = 1'b0,
        WORD_QUOTE   = 1'b1
    } word_sel_t;

    // One classified input request: a flush of a broken escape, an optional
    // single byte, and an optional flush at end of text.
    typedef struct packed {
        logic [3:0] a_len;      // backslash plus matched letters, 0 if none
        word_sel_t  a_sel;
        logic       b_valid;    // single byte present
        logic [7:0] b_char;
        word_sel_t  c_sel;      // word of the end-of-text flush
        logic [2:0] last_idx;   // index of the last result of this request
        logic       text_end;
    } cmd_t;

    // Match state of the front, seen by checks at the top level.
    typedef struct packed {
        logic       pending;
        word_sel_t  sel;
        logic [2:0] count;
    } front_stat_t;

    // Number of letters in the selected word.
    function automatic logic [2:0] word_len(input word_sel_t sel);
        logic [2:0] len;
        len = (sel == WORD_QUOTE) ? QUOTE_LEN : NEWLINE_LEN;
        return len;
    endfunction

    // Letter at a position of the selected word.
    function automatic logic [7:0] word_char(input word_sel_t sel, input logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        if (sel == WORD_QUOTE) begin
            unique case (idx)
                3'd0:    ch = 8'h71;  // q
                3'd1:    ch = 8'h75;  // u
                3'd2:    ch = 8'h6F;  // o
                3'd3:    ch = 8'h74;  // t
                3'd4:    ch = 8'h65;  // e
                default: ch = 8'h00;
            endcase
        end else begin
            unique case (idx)
                3'd0:    ch = 8'h6E;  // n
                3'd1:    ch = 8'h65;  // e
                3'd2:    ch = 8'h77;  // w
                3'd3:    ch = 8'h6C;  // l
                3'd4:    ch = 8'h69;  // i
                3'd5:    ch = 8'h6E;  // n
                3'd6:    ch = 8'h65;  // e
                default: ch = 8'h00;
            endcase
        end
        return ch;
    endfunction

    // Matched letters that can be replayed, limited to the word length.
    function automatic logic [2:0] clamp_count(input word_sel_t sel, input logic [2:0] count);
        logic [2:0] len;
        len = word_len(sel);
        return (count > len) ? len : count;
    endfunction

endpackage

// File: src/ewu_front.sv
// Front part: tracks the escape match state and classifies each input byte.
`timescale 1ns / 1ps

module ewu_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic [7:0]           in_char,
    input  logic                 end_of_text,
    output ewu_pkg::cmd_t        cmd,
    output logic                 cmd_nonempty,
    output ewu_pkg::front_stat_t stat
);

    logic                pending_reg, pending_next;
    ewu_pkg::word_sel_t  sel_reg, sel_next;
    logic [2:0]          count_reg, count_next;

    logic                consumed;
    logic [2:0]          len;
    logic [3:0]          a_len;
    logic [3:0]          c_len;
    ewu_pkg::word_sel_t  c_sel;
    logic                b_valid;
    logic [7:0]          b_char;
    logic [3:0]          total;

    // Match the byte against the pending escape, then handle it from idle.
    always_comb begin
        pending_next = pending_reg;
        sel_next     = sel_reg;
        count_next   = count_reg;
        consumed     = 1'b0;
        a_len        = 4'd0;
        c_len        = 4'd0;
        c_sel        = ewu_pkg::WORD_NEWLINE;
        b_valid      = 1'b0;
        b_char       = in_char;
        len          = ewu_pkg::word_len(sel_reg);

        if (pending_reg) begin
            if (count_reg == 3'd0) begin
                if (in_char == ewu_pkg::LETTER_N) begin
                    consumed   = 1'b1;
                    sel_next   = ewu_pkg::WORD_NEWLINE;
                    count_next = 3'd1;
                end else if (in_char == ewu_pkg::LETTER_Q) begin
                    consumed   = 1'b1;
                    sel_next   = ewu_pkg::WORD_QUOTE;
                    count_next = 3'd1;
                end
            end else if (count_reg < len
                         && in_char == ewu_pkg::word_char(sel_reg, count_reg)) begin
                consumed = 1'b1;
                if (count_reg + 3'd1 == len) begin
                    // Word complete: emit the decoded byte and go idle.
                    b_valid      = 1'b1;
                    b_char       = (sel_reg == ewu_pkg::WORD_QUOTE) ?
                                   ewu_pkg::DQUOTE_CHAR : ewu_pkg::LINEFEED_CHAR;
                    pending_next = 1'b0;
                    sel_next     = ewu_pkg::WORD_NEWLINE;
                    count_next   = 3'd0;
                end else begin
                    count_next = count_reg + 3'd1;
                end
            end
            if (!consumed) begin
                // Mismatch: replay the backslash and the matched letters.
                a_len        = 4'd1 + {1'b0, ewu_pkg::clamp_count(sel_reg, count_reg)};
                pending_next = 1'b0;
                sel_next     = ewu_pkg::WORD_NEWLINE;
                count_next   = 3'd0;
            end
        end

        if (!consumed) begin
            if (in_char == ewu_pkg::BACKSLASH_CHAR) begin
                pending_next = 1'b1;
                sel_next     = ewu_pkg::WORD_NEWLINE;
                count_next   = 3'd0;
            end else begin
                b_valid = 1'b1;
                b_char  = in_char;
            end
        end

        // End of text flushes whatever escape is still open.
        if (end_of_text && pending_next) begin
            c_len        = 4'd1 + {1'b0, ewu_pkg::clamp_count(sel_next, count_next)};
            c_sel        = sel_next;
            pending_next = 1'b0;
            sel_next     = ewu_pkg::WORD_NEWLINE;
            count_next   = 3'd0;
        end

        total = a_len + {3'd0, b_valid} + c_len;
    end

    // Assemble the request for the back part.
    always_comb begin
        cmd.a_len    = a_len;
        cmd.a_sel    = sel_reg;
        cmd.b_valid  = b_valid;
        cmd.b_char   = b_char;
        cmd.c_sel    = c_sel;
        cmd.last_idx = 3'(total - 4'd1);
        cmd.text_end = end_of_text;
        cmd_nonempty = (total != 4'd0);
        stat.pending = pending_reg;
        stat.sel     = sel_reg;
        stat.count   = count_reg;
    end

    // Match state advances on every accepted byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
            sel_reg     <= ewu_pkg::WORD_NEWLINE;
            count_reg   <= 3'd0;
        end else if (accept) begin
            pending_reg <= pending_next;
            sel_reg     <= sel_next;
            count_reg   <= count_next;
        end
    end

endmodule

// File: src/ewu_queue.sv
// Short request queue between the front and back parts.
`timescale 1ns / 1ps

module ewu_queue #(
    parameter int DEPTH = ewu_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  ewu_pkg::cmd_t push_cmd,
    input  logic          pop,
    output ewu_pkg::cmd_t head_cmd,
    output logic          head_valid,
    output logic          full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ewu_pkg::cmd_t      entries [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_cmd   = entries[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count update with wraparound at the depth.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: src/ewu_back.sv
// Back part: expands each queued request into result bytes, one per cycle unless the receiver stalls.
`timescale 1ns / 1ps

module ewu_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  ewu_pkg::cmd_t head_cmd,
    input  logic          head_valid,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_out_char,
    output logic          m_text_end,
    output logic          m_run_last
);

    logic [2:0] pos_reg, pos_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg;
    logic       text_end_reg;
    logic       run_last_reg;

    logic       load;
    logic       step;
    logic       last;
    logic [3:0] pos_w;
    logic [3:0] c_idx;
    logic [7:0] byte_sel;

    assign load = !out_valid_reg || m_ready;
    assign step = load && head_valid;
    assign last = (pos_reg == head_cmd.last_idx);
    assign pop  = step && last;
    assign pos_w = {1'b0, pos_reg};
    assign c_idx = pos_w - head_cmd.a_len - {3'd0, head_cmd.b_valid};

    // Pick the byte at the current position of the request.
    always_comb begin
        if (pos_w < head_cmd.a_len) begin
            byte_sel = (pos_reg == 3'd0) ? ewu_pkg::BACKSLASH_CHAR
                     : ewu_pkg::word_char(head_cmd.a_sel, pos_reg - 3'd1);
        end else if (head_cmd.b_valid && pos_w == head_cmd.a_len) begin
            byte_sel = head_cmd.b_char;
        end else begin
            byte_sel = (c_idx == 4'd0) ? ewu_pkg::BACKSLASH_CHAR
                     : ewu_pkg::word_char(head_cmd.c_sel, c_idx[2:0] - 3'd1);
        end
    end

    always_comb begin
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = head_valid;
        end
        if (step) begin
            pos_next = last ? 3'd0 : pos_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (step) begin
            out_char_reg <= byte_sel;
            run_last_reg <= last;
            text_end_reg <= last && head_cmd.text_end;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_out_char = out_char_reg;
    assign m_text_end = text_end_reg;
    assign m_run_last = run_last_reg;

endmodule

// File: src/escape_word_unescaper.sv
// Escape word unescaper: a backslash followed by "newline" or "quote" becomes
// a line feed or a double quote; the input takes one byte per cycle while the
// request queue has room, and every byte that produces no output (letters of
// an escape in progress) pushes no request. A byte that produces k results
// (up to eight, after a broken escape or at end of text) holds the output
// sequencer for all k, one result per cycle while the receiver accepts; the
// four-entry request queue between the classifier and the sequencer absorbs
// such bursts, so the input stalls only when long flushes follow each other
// closely or when the receiver holds off long enough to fill the queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module escape_word_unescaper #(
    parameter int QUEUE_DEPTH = ewu_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_char,
    input  logic       s_end_of_text,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_text_end,
    output logic       m_run_last
);

    ewu_pkg::cmd_t        front_cmd;
    ewu_pkg::cmd_t        head_cmd;
    ewu_pkg::front_stat_t front_stat;
    logic                 cmd_nonempty;
    logic                 accept;
    logic                 q_full;
    logic                 head_valid;
    logic                 pop;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    ewu_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .in_char      (s_in_char),
        .end_of_text  (s_end_of_text),
        .cmd          (front_cmd),
        .cmd_nonempty (cmd_nonempty),
        .stat         (front_stat)
    );

    ewu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept && cmd_nonempty),
        .push_cmd   (front_cmd),
        .pop        (pop),
        .head_cmd   (head_cmd),
        .head_valid (head_valid),
        .full       (q_full)
    );

    ewu_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_cmd   (head_cmd),
        .head_valid (head_valid),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_text_end (m_text_end),
        .m_run_last (m_run_last)
    );

    // The end-of-text marker only ever rides on the last result of a request.
    `EWU_ASSERT(a_text_end_is_last, (m_valid && m_text_end) |-> m_run_last, "text_end without run_last")

    // After the final byte of a text the front holds no open escape.
    `EWU_ASSERT(a_idle_after_end, (accept && s_end_of_text) |=> !front_stat.pending, "escape left open after end of text")

    // A pending match never runs past the length of its word.
    `EWU_ASSERT(a_count_in_word, front_stat.pending |-> (front_stat.count < ewu_pkg::word_len(front_stat.sel)), "matched count beyond word length")

    // The final byte of a text always produces at least one result.
    `EWU_NEVER(a_push_nonempty, accept && !cmd_nonempty && s_end_of_text, "end of text produced no result")

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the escape word unescaper, with its own decoder model.
`timescale 1ns / 1ps

module tb_top;

    // One raw text byte with the idle cycles that precede its request.
    typedef struct {
        logic [7:0] ch;
        logic       eot;
        int         gap;
    } text_req_t;

    // One decoded byte as it should leave the block.
    typedef struct {
        logic [7:0] ch;
        logic       text_end;
        logic       run_last;
    } decoded_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_char;
    logic       s_end_of_text;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_char;
    logic       m_text_end;
    logic       m_run_last;

    text_req_t  text_queue[$];
    decoded_t   decoded_queue[$];
    logic [7:0] step_bytes[$];

    // Decoder model state.
    logic                esc_pending;
    ewu_pkg::word_sel_t  esc_word;
    logic [2:0]          esc_count;

    int  error_count;
    int  items_sent;
    int  results_seen;
    int  queued_total;
    bit  in_taken;
    bit  out_taken;

    escape_word_unescaper DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_char     (s_in_char),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_text_end    (m_text_end),
        .m_run_last    (m_run_last)
    );

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Letters of the two escape words.
    function automatic logic [7:0] word_letter(input ewu_pkg::word_sel_t w, input int idx);
        string s;
        s = (w == ewu_pkg::WORD_QUOTE) ? "quote" : "newline";
        return s[idx];
    endfunction

    function automatic logic [2:0] word_length(input ewu_pkg::word_sel_t w);
        return (w == ewu_pkg::WORD_QUOTE) ? ewu_pkg::QUOTE_LEN : ewu_pkg::NEWLINE_LEN;
    endfunction

    // Emit the backslash and the letters matched so far, then return to idle.
    task automatic flush_partial();
        logic [2:0] n;
        n = (esc_count > word_length(esc_word)) ? word_length(esc_word) : esc_count;
        step_bytes.push_back(ewu_pkg::BACKSLASH_CHAR);
        for (int i = 0; i < n; i++) begin
            step_bytes.push_back(word_letter(esc_word, i));
        end
        esc_pending = 1'b0;
        esc_word    = ewu_pkg::WORD_NEWLINE;
        esc_count   = 3'd0;
    endtask

    // Decode one accepted byte and queue the bytes it should produce.
    task automatic decode_byte(input logic [7:0] c, input logic eot);
        bit       taken;
        decoded_t d;
        taken = 0;
        step_bytes.delete();
        if (esc_pending) begin
            if (esc_count == 3'd0) begin
                if (c == ewu_pkg::LETTER_N) begin
                    esc_word  = ewu_pkg::WORD_NEWLINE;
                    esc_count = 3'd1;
                    taken     = 1;
                end else if (c == ewu_pkg::LETTER_Q) begin
                    esc_word  = ewu_pkg::WORD_QUOTE;
                    esc_count = 3'd1;
                    taken     = 1;
                end
            end else if (esc_count < word_length(esc_word) &&
                         c == word_letter(esc_word, esc_count)) begin
                taken = 1;
                if (esc_count + 1 == word_length(esc_word)) begin
                    step_bytes.push_back((esc_word == ewu_pkg::WORD_QUOTE) ?
                                         ewu_pkg::DQUOTE_CHAR : ewu_pkg::LINEFEED_CHAR);
                    esc_pending = 1'b0;
                    esc_word    = ewu_pkg::WORD_NEWLINE;
                    esc_count   = 3'd0;
                end else begin
                    esc_count = esc_count + 3'd1;
                end
            end
            if (!taken) flush_partial();
        end
        // A byte not absorbed by an escape is handled as if the decoder were idle.
        if (!taken) begin
            if (c == ewu_pkg::BACKSLASH_CHAR) begin
                esc_pending = 1'b1;
                esc_word    = ewu_pkg::WORD_NEWLINE;
                esc_count   = 3'd0;
            end else begin
                step_bytes.push_back(c);
            end
        end
        if (eot && esc_pending) flush_partial();
        for (int k = 0; k < step_bytes.size(); k++) begin
            d.ch       = step_bytes[k];
            d.run_last = (k == step_bytes.size() - 1);
            d.text_end = d.run_last && eot;
            decoded_queue.push_back(d);
        end
    endtask

    // Queue one request; some stretches of the stream run without gaps.
    task automatic add_byte(input logic [7:0] c, input logic eot);
        text_req_t r;
        r.ch  = c;
        r.eot = eot;
        r.gap = (((queued_total / 30) % 3) == 1) ? 0 : $urandom_range(0, 7);
        text_queue.push_back(r);
        queued_total++;
    endtask

    task automatic add_word(input ewu_pkg::word_sel_t w, input int letters,
                            input logic eot_last);
        add_byte(ewu_pkg::BACKSLASH_CHAR, (letters == 0) ? eot_last : 1'b0);
        for (int i = 0; i < letters; i++) begin
            add_byte(word_letter(w, i), (i == letters - 1) ? eot_last : 1'b0);
        end
    endtask

    // One random sequence: well-formed escapes most often, also broken ones and noise.
    task automatic add_random_sequence();
        int                  kind;
        int                  n;
        ewu_pkg::word_sel_t  w;
        kind = $urandom_range(0, 9);
        w    = ($urandom_range(0, 1) == 1) ? ewu_pkg::WORD_QUOTE : ewu_pkg::WORD_NEWLINE;
        n    = $urandom_range(0, word_length(w) - 1);
        case (kind)
            0, 1, 2: begin
                add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
            3, 4, 5, 6: begin
                add_word(w, int'(word_length(w)), $urandom_range(0, 5) == 0);
            end
            7: begin
                add_word(w, n, 1'b0);
                add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
            8: begin
                add_byte(ewu_pkg::BACKSLASH_CHAR, 1'b0);
                add_byte(ewu_pkg::BACKSLASH_CHAR, $urandom_range(0, 1) == 1);
            end
            default: begin
                add_word(w, n, 1'b1);
            end
        endcase
    endtask

    // Stimulus, drain and final verdict.
    initial begin
        text_req_t r;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_in_char     = 8'h00;
        s_end_of_text = 1'b0;
        m_ready       = 1'b0;
        esc_pending   = 1'b0;
        esc_word      = ewu_pkg::WORD_NEWLINE;
        esc_count     = 3'd0;
        error_count   = 0;
        items_sent    = 0;
        results_seen  = 0;
        queued_total  = 0;
        in_taken      = 0;
        out_taken     = 0;

        // Directed part: byte zero, both words, broken escapes, flushes at end.
        add_byte(8'h00, 1'b0);
        add_word(ewu_pkg::WORD_NEWLINE, 7, 1'b0);
        add_word(ewu_pkg::WORD_QUOTE, 5, 1'b1);
        add_word(ewu_pkg::WORD_NEWLINE, 6, 1'b0);
        add_byte(8'hFF, 1'b1);
        add_byte(ewu_pkg::BACKSLASH_CHAR, 1'b0);
        add_byte(ewu_pkg::LETTER_Q, 1'b0);
        add_byte(ewu_pkg::BACKSLASH_CHAR, 1'b1);
        add_byte(ewu_pkg::BACKSLASH_CHAR, 1'b1);
        add_word(ewu_pkg::WORD_QUOTE, 3, 1'b1);

        // Random part, with a gapless run of plain bytes to fill the block.
        while (queued_total < 200) begin
            if (queued_total >= 110 && queued_total < 115) begin
                for (int i = 0; i < 60; i++) begin
                    r.ch  = 8'($urandom_range(0, 255));
                    r.ch  = (r.ch == ewu_pkg::BACKSLASH_CHAR) ? 8'h00 : r.ch;
                    r.eot = (i == 59);
                    r.gap = 0;
                    text_queue.push_back(r);
                    queued_total++;
                end
            end else begin
                add_random_sequence();
            end
        end

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Wait for every request to be accepted and every result to arrive.
        while (items_sent < queued_total || decoded_queue.size() != 0) begin
            @(negedge aclk);
        end
        repeat (20) @(negedge aclk);

        if (error_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2000000;
        $display("tb_top: errors");
        $finish;
    end

    // Request driver: presents the next byte after its gap, holds until accepted.
    text_req_t cur_req;
    bit        req_loaded;
    int        gap_left;
    initial begin
        req_loaded = 0;
        gap_left   = 0;
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (!req_loaded && text_queue.size() != 0) begin
                cur_req    = text_queue.pop_front();
                gap_left   = cur_req.gap;
                req_loaded = 1;
            end
            if (req_loaded && gap_left == 0) begin
                s_in_char     <= cur_req.ch;
                s_end_of_text <= cur_req.eot;
                s_valid       <= 1'b1;
                req_loaded     = 0;
            end else begin
                s_valid <= 1'b0;
                if (req_loaded) gap_left--;
            end
        end
    end

    // Result receiver: random stalls, quiet stretches, and one long hold-off.
    int wait_left;
    int hold_left;
    bit hold_done;
    initial begin
        wait_left = 0;
        hold_left = 0;
        hold_done = 0;
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (!hold_done && items_sent >= 120) begin
                hold_left = 150;
                hold_done = 1;
            end
            if (out_taken) begin
                wait_left = (((results_seen / 25) % 3) == 0) ? 0 : $urandom_range(0, 7);
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (wait_left > 0) begin
                m_ready <= 1'b0;
                wait_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Monitor: checks each result against the oldest expected byte and
    // feeds accepted requests to the decoder model.
    always @(posedge aclk) begin
        decoded_t want;
        in_taken  = 0;
        out_taken = 0;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                out_taken = 1;
                results_seen++;
                if (decoded_queue.size() == 0) begin
                    $error("unexpected result: out_char %h", m_out_char);
                    error_count++;
                end else begin
                    want = decoded_queue.pop_front();
                    if (m_out_char !== want.ch) begin
                        $error("out_char: expected %h, actual %h", want.ch, m_out_char);
                        error_count++;
                    end
                    if (m_text_end !== want.text_end) begin
                        $error("text_end: expected %b, actual %b", want.text_end, m_text_end);
                        error_count++;
                    end
                    if (m_run_last !== want.run_last) begin
                        $error("run_last: expected %b, actual %b", want.run_last, m_run_last);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                in_taken = 1;
                items_sent++;
                decode_byte(s_in_char, s_end_of_text);
            end
        end
    end

endmodule

// File: files.f
+incdir+src
src/ewu_pkg.sv
src/ewu_front.sv
src/ewu_queue.sv
src/ewu_back.sv
src/escape_word_unescaper.sv
tb/tb_top.sv
